// ===== hdl/rsi_pkg.sv =====
`default_nettype none
package rsi_pkg;

  // Widths of the coordinate fields and the wide intermediate products.
  localparam int CoordW = 32;
  localparam int QuotW  = 41;             // quotient bits 40..0
  localparam int NumW   = 100;            // numerator magnitude
  localparam int DenW   = 66;             // determinant magnitude
  localparam int CmpW   = DenW + QuotW;   // widest divider compare
  localparam int SqW    = 84;             // sum of the two squares
  localparam int RootW  = 34;             // square root bits 33..0
  localparam int DistW  = 33;

  // Largest quotient magnitude; anything beyond saturates here.
  localparam logic [QuotW-1:0] QUOT_LIMIT = QuotW'(1) << (QuotW - 1);

  // Configuration register indexes.
  localparam logic [7:0] REG_SEG_START_X = 8'd0;
  localparam logic [7:0] REG_SEG_START_Y = 8'd1;
  localparam logic [7:0] REG_SEG_END_X   = 8'd2;
  localparam logic [7:0] REG_SEG_END_Y   = 8'd3;

  // Per-item data that rides along with the division.
  typedef struct packed {
    logic                     miss;
    logic                     dom_x;
    logic                     x_neg;
    logic                     y_neg;
    logic signed [CoordW-1:0] ox;
    logic signed [CoordW-1:0] oy;
    logic signed [CoordW-1:0] dx;
    logic signed [CoordW-1:0] dy;
  } rsi_side_t;

endpackage
`default_nettype wire

// ===== hdl/rsi_div.sv =====
`default_nettype none
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage. A first stage flags quotients that reach 2^41.
module rsi_div
  import rsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [NumW-1:0]       in_nx,
  input  logic [NumW-1:0]       in_ny,
  input  logic [DenW-1:0]       in_den,
  input  rsi_side_t             in_side,
  output logic                  out_valid,
  output logic [QuotW-1:0]      out_qx,
  output logic [QuotW-1:0]      out_qy,
  output logic                  out_sat_x,
  output logic                  out_sat_y,
  output rsi_side_t             out_side
);

  logic [QuotW:0]       vld;
  logic [QuotW:0]       sat_x;
  logic [QuotW:0]       sat_y;
  logic [NumW-1:0]      rem_x [QuotW+1];
  logic [NumW-1:0]      rem_y [QuotW+1];
  logic [QuotW-1:0]     quo_x [QuotW+1];
  logic [QuotW-1:0]     quo_y [QuotW+1];
  logic [DenW-1:0]      den   [QuotW+1];
  rsi_side_t            side  [QuotW+1];
  logic [CmpW-1:0]      den_top;

  assign den_top = {in_den, {QuotW{1'b0}}};

  // Entry stage: overflow check against the divisor shifted past the top bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x[0] <= in_nx;
      rem_y[0] <= in_ny;
      sat_x[0] <= CmpW'(in_nx) >= den_top;
      sat_y[0] <= CmpW'(in_ny) >= den_top;
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      den[0]   <= in_den;
      side[0]  <= in_side;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 1; i <= QuotW; i++) begin : g_step
    localparam int K = QuotW - i;
    logic [CmpW-1:0] trial;
    logic [CmpW-1:0] rx_ext;
    logic [CmpW-1:0] ry_ext;
    logic            take_x;
    logic            take_y;

    assign trial  = CmpW'(den[i-1]) << K;
    assign rx_ext = CmpW'(rem_x[i-1]);
    assign ry_ext = CmpW'(rem_y[i-1]);
    assign take_x = rx_ext >= trial;
    assign take_y = ry_ext >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[i] <= take_x ? NumW'(rx_ext - trial) : rem_x[i-1];
        rem_y[i] <= take_y ? NumW'(ry_ext - trial) : rem_y[i-1];
        quo_x[i] <= quo_x[i-1] | (QuotW'(take_x) << K);
        quo_y[i] <= quo_y[i-1] | (QuotW'(take_y) << K);
        sat_x[i] <= sat_x[i-1];
        sat_y[i] <= sat_y[i-1];
        den[i]   <= den[i-1];
        side[i]  <= side[i-1];
      end
    end
  end

  assign out_valid = vld[QuotW];
  assign out_qx    = quo_x[QuotW];
  assign out_qy    = quo_y[QuotW];
  assign out_sat_x = sat_x[QuotW];
  assign out_sat_y = sat_y[QuotW];
  assign out_side  = side[QuotW];

endmodule
`default_nettype wire

// ===== hdl/rsi_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage. The remainder
// holds the value minus the square of the bits found so far.
module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SqW-1:0]   in_sum,
  input  logic             in_hit,
  output logic             out_valid,
  output logic [RootW-1:0] out_root,
  output logic             out_hit
);

  logic [RootW:0]     vld;
  logic [RootW:0]     hit;
  logic [SqW-1:0]     rem  [RootW+1];
  logic [RootW-1:0]   root [RootW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= in_sum;
      root[0] <= '0;
      hit[0]  <= in_hit;
    end
  end

  // Setting bit B adds 2*root*2^B + 2^(2B) to the square.
  for (genvar i = 1; i <= RootW; i++) begin : g_step
    localparam int B = RootW - i;
    logic [SqW-1:0] trial;
    logic           take;

    assign trial = (SqW'(root[i-1]) << (B + 1)) | (SqW'(1) << (2 * B));
    assign take  = rem[i-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= take ? rem[i-1] - trial : rem[i-1];
        root[i] <= root[i-1] | (RootW'(take) << B);
        hit[i]  <= hit[i-1];
      end
    end
  end

  assign out_valid = vld[RootW];
  assign out_root  = root[RootW];
  assign out_hit   = hit[RootW];

endmodule
`default_nettype wire

// ===== hdl/ray_segment_intersection_unit.sv =====
`default_nettype none
// Tests a stream of 2D rays against one segment held in four registers and
// returns, per ray, a hit flag and the distance from the origin to the
// crossing point (0 on a miss); coordinates are signed Q16.16, the distance
// unsigned Q17.16. One ray is taken every clock cycle unless the skid stage
// is full. Most stages lie in the 42-stage divider (one quotient bit per
// stage) and the 35-stage square root (one root bit per stage). An output
// register with a skid stage catches a result arriving while the output
// waits; the pipe stalls while the skid is full. After a register write,
// allow a few cycles before the next ray so the derived segment terms settle.
module ray_segment_intersection_unit
  import rsi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // origin_x, origin_y, dir_x, dir_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // distance, zero fill
  output logic         m_tuser    // hit
);

  function automatic logic [CoordW:0] mag32(logic signed [CoordW-1:0] v);
    logic signed [CoordW:0] w;
    w = (CoordW+1)'(v);
    mag32 = w[CoordW] ? unsigned'(-w) : unsigned'(w);
  endfunction

  function automatic logic outside_box(logic signed [41:0] r,
                                       logic signed [CoordW-1:0] p,
                                       logic signed [CoordW-1:0] q);
    outside_box = (r > 42'(p) && r > 42'(q)) || (r < 42'(p) && r < 42'(q));
  endfunction

  function automatic logic same_sign(logic signed [42:0] u,
                                     logic signed [CoordW-1:0] d);
    same_sign = ((u > 0) == (d > 0)) && ((u < 0) == (d < 0));
  endfunction

  // Configuration registers.
  logic signed [CoordW-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEG_START_X: seg_start_x <= signed'(cfg_data);
        REG_SEG_START_Y: seg_start_y <= signed'(cfg_data);
        REG_SEG_END_X:   seg_end_x   <= signed'(cfg_data);
        REG_SEG_END_Y:   seg_end_y   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Segment terms that depend on the registers alone.
  logic signed [CoordW:0]   seg_ex, seg_ey;
  logic signed [63:0]       prod_a, prod_b;
  logic signed [64:0]       c1;
  logic        [31:0]       c1_lo;
  logic signed [32:0]       c1_hi;

  always_ff @(posedge clk) begin
    seg_ex <= (CoordW+1)'(seg_start_x) - (CoordW+1)'(seg_end_x);
    seg_ey <= (CoordW+1)'(seg_start_y) - (CoordW+1)'(seg_end_y);
    prod_a <= seg_start_x * seg_end_y;
    prod_b <= seg_start_y * seg_end_x;
    c1     <= 65'(prod_a) - 65'(prod_b);
  end

  assign c1_lo = c1[31:0];
  assign c1_hi = signed'(c1[64:32]);

  // Pipeline enable: the whole pipe moves unless the skid stage is full.
  logic en;
  logic skid_v;

  assign en       = !skid_v;
  assign s_tready = en;

  // Stage 1: register the ray.
  logic                     v1;
  logic signed [CoordW-1:0] ox1, oy1, dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox1 <= signed'(s_tdata[31:0]);
      oy1 <= signed'(s_tdata[63:32]);
      dx1 <= signed'(s_tdata[95:64]);
      dy1 <= signed'(s_tdata[127:96]);
    end
  end

  // Stage 2: first products.
  logic                     v2, zero2, dom2;
  logic signed [CoordW-1:0] ox2, oy2, dx2, dy2;
  logic signed [64:0]       det_a2, det_b2;
  logic signed [63:0]       m1_2, m2_2;
  logic signed [64:0]       cx_lo2, cx_hi2, cy_lo2, cy_hi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_a2 <= seg_ex * dy1;
      det_b2 <= seg_ey * dx1;
      m1_2   <= dx1 * oy1;
      m2_2   <= dy1 * ox1;
      cx_lo2 <= dx1 * $signed({1'b0, c1_lo});
      cx_hi2 <= dx1 * c1_hi;
      cy_lo2 <= dy1 * $signed({1'b0, c1_lo});
      cy_hi2 <= dy1 * c1_hi;
      zero2  <= (dx1 == '0) && (dy1 == '0);
      dom2   <= mag32(dx1) > mag32(dy1);
      ox2 <= ox1;
      oy2 <= oy1;
      dx2 <= dx1;
      dy2 <= dy1;
    end
  end

  // Stage 3: determinant, second cross term, and c1 times direction.
  logic                     v3, zero3, dom3;
  logic signed [CoordW-1:0] ox3, oy3, dx3, dy3;
  logic signed [65:0]       det3;
  logic signed [64:0]       c2_3;
  logic signed [97:0]       cdx3, cdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det3  <= 66'(det_a2) - 66'(det_b2);
      c2_3  <= 65'(m1_2) - 65'(m2_2);
      cdx3  <= (98'(cx_hi2) <<< 32) + 98'(cx_lo2);
      cdy3  <= (98'(cy_hi2) <<< 32) + 98'(cy_lo2);
      zero3 <= zero2;
      dom3  <= dom2;
      ox3 <= ox2;
      oy3 <= oy2;
      dx3 <= dx2;
      dy3 <= dy2;
    end
  end

  // Stage 4: segment differences times the second cross term, in halves.
  logic                     v4, zero4, dom4;
  logic signed [CoordW-1:0] ox4, oy4, dx4, dy4;
  logic signed [65:0]       det4;
  logic signed [97:0]       cdx4, cdy4;
  logic signed [65:0]       exc_lo4, exc_hi4, eyc_lo4, eyc_hi4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exc_lo4 <= seg_ex * $signed({1'b0, c2_3[31:0]});
      exc_hi4 <= seg_ex * $signed(c2_3[64:32]);
      eyc_lo4 <= seg_ey * $signed({1'b0, c2_3[31:0]});
      eyc_hi4 <= seg_ey * $signed(c2_3[64:32]);
      det4  <= det3;
      cdx4  <= cdx3;
      cdy4  <= cdy3;
      zero4 <= zero3;
      dom4  <= dom3;
      ox4 <= ox3;
      oy4 <= oy3;
      dx4 <= dx3;
      dy4 <= dy3;
    end
  end

  // Stage 5: join the halves.
  logic                     v5, zero5, dom5;
  logic signed [CoordW-1:0] ox5, oy5, dx5, dy5;
  logic signed [65:0]       det5;
  logic signed [97:0]       cdx5, cdy5, exc5, eyc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exc5  <= (98'(exc_hi4) <<< 32) + 98'(exc_lo4);
      eyc5  <= (98'(eyc_hi4) <<< 32) + 98'(eyc_lo4);
      det5  <= det4;
      cdx5  <= cdx4;
      cdy5  <= cdy4;
      zero5 <= zero4;
      dom5  <= dom4;
      ox5 <= ox4;
      oy5 <= oy4;
      dx5 <= dx4;
      dy5 <= dy4;
    end
  end

  // Stage 6: numerators.
  logic                     v6, zero6, dom6;
  logic signed [CoordW-1:0] ox6, oy6, dx6, dy6;
  logic signed [65:0]       det6;
  logic signed [NumW-1:0]   nx6, ny6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx6   <= NumW'(cdx5) - NumW'(exc5);
      ny6   <= NumW'(cdy5) - NumW'(eyc5);
      det6  <= det5;
      zero6 <= zero5;
      dom6  <= dom5;
      ox6 <= ox5;
      oy6 <= oy5;
      dx6 <= dx5;
      dy6 <= dy5;
    end
  end

  // Stage 7: magnitudes and signs for the divider.
  logic             v7;
  logic [NumW-1:0]  nm_x7, nm_y7;
  logic [DenW-1:0]  dm7;
  rsi_side_t        side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_x7       <= nx6[NumW-1] ? unsigned'(-nx6) : unsigned'(nx6);
      nm_y7       <= ny6[NumW-1] ? unsigned'(-ny6) : unsigned'(ny6);
      dm7         <= det6[DenW-1] ? unsigned'(-det6) : unsigned'(det6);
      side7.miss  <= zero6 || (det6 == '0);
      side7.dom_x <= dom6;
      side7.x_neg <= nx6[NumW-1] ^ det6[DenW-1];
      side7.y_neg <= ny6[NumW-1] ^ det6[DenW-1];
      side7.ox    <= ox6;
      side7.oy    <= oy6;
      side7.dx    <= dx6;
      side7.dy    <= dy6;
    end
  end

  // Division of both numerators by the determinant.
  logic             dv;
  logic [QuotW-1:0] dqx, dqy;
  logic             dsat_x, dsat_y;
  rsi_side_t        dside;

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_nx     (nm_x7),
    .in_ny     (nm_y7),
    .in_den    (dm7),
    .in_side   (side7),
    .out_valid (dv),
    .out_qx    (dqx),
    .out_qy    (dqy),
    .out_sat_x (dsat_x),
    .out_sat_y (dsat_y),
    .out_side  (dside)
  );

  // Stage T1: saturate and sign the intersection point.
  logic               t1_v;
  logic signed [41:0] rx_t1, ry_t1;
  rsi_side_t          side_t1;
  logic [QuotW-1:0]   qx_sat, qy_sat;

  assign qx_sat = (dsat_x || dqx > QUOT_LIMIT) ? QUOT_LIMIT : dqx;
  assign qy_sat = (dsat_y || dqy > QUOT_LIMIT) ? QUOT_LIMIT : dqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (en) begin
      t1_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_t1   <= dside.x_neg ? -$signed(42'(qx_sat)) : $signed(42'(qx_sat));
      ry_t1   <= dside.y_neg ? -$signed(42'(qy_sat)) : $signed(42'(qy_sat));
      side_t1 <= dside;
    end
  end

  // Stage T2: bounding box test and offset from the origin.
  logic               t2_v, miss_t2;
  logic signed [42:0] ux_t2, uy_t2;
  rsi_side_t          side_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else if (en) begin
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_t2   <= 43'(rx_t1) - 43'(side_t1.ox);
      uy_t2   <= 43'(ry_t1) - 43'(side_t1.oy);
      side_t2 <= side_t1;
      miss_t2 <= side_t1.miss
                 || outside_box(rx_t1, seg_start_x, seg_end_x)
                 || outside_box(ry_t1, seg_start_y, seg_end_y);
    end
  end

  // Stage T3: the point must lie ahead of the origin on the dominant axis.
  logic        t3_v, miss_t3;
  logic [41:0] umx_t3, umy_t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else if (en) begin
      t3_v <= t2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      umx_t3  <= ux_t2[42] ? 42'(-ux_t2) : 42'(ux_t2);
      umy_t3  <= uy_t2[42] ? 42'(-uy_t2) : 42'(uy_t2);
      miss_t3 <= miss_t2 || (side_t2.dom_x ? !same_sign(ux_t2, side_t2.dx)
                                           : !same_sign(uy_t2, side_t2.dy));
    end
  end

  // Stage T4: squares as 21-bit partial products.
  logic        t4_v, miss_t4;
  logic [41:0] xhh, xhl, xll, yhh, yhl, yll;

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_v <= 1'b0;
    end else if (en) begin
      t4_v <= t3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xhh     <= umx_t3[41:21] * umx_t3[41:21];
      xhl     <= umx_t3[41:21] * umx_t3[20:0];
      xll     <= umx_t3[20:0] * umx_t3[20:0];
      yhh     <= umy_t3[41:21] * umy_t3[41:21];
      yhl     <= umy_t3[41:21] * umy_t3[20:0];
      yll     <= umy_t3[20:0] * umy_t3[20:0];
      miss_t4 <= miss_t3;
    end
  end

  // Stage T5: assemble each square.
  logic           t5_v, miss_t5;
  logic [SqW-1:0] sqx_t5, sqy_t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      t5_v <= 1'b0;
    end else if (en) begin
      t5_v <= t4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_t5  <= (SqW'(xhh) << 42) + (SqW'(xhl) << 22) + SqW'(xll);
      sqy_t5  <= (SqW'(yhh) << 42) + (SqW'(yhl) << 22) + SqW'(yll);
      miss_t5 <= miss_t4;
    end
  end

  // Stage T6: sum of squares.
  logic           t6_v, hit_t6;
  logic [SqW-1:0] sum_t6;

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_v <= 1'b0;
    end else if (en) begin
      t6_v <= t5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_t6 <= sqx_t5 + sqy_t5;
      hit_t6 <= !miss_t5;
    end
  end

  // Distance.
  logic             sv, s_hit;
  logic [RootW-1:0] s_root;

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t6_v),
    .in_sum    (sum_t6),
    .in_hit    (hit_t6),
    .out_valid (sv),
    .out_root  (s_root),
    .out_hit   (s_hit)
  );

  // Output register with a skid stage behind it.
  logic             arrive;
  logic [DistW-1:0] new_dist;
  logic             out_v, out_hit, skid_hit;
  logic [DistW-1:0] out_dist, skid_dist;

  assign arrive   = sv && en;
  assign new_dist = s_hit ? s_root[DistW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      out_v  <= skid_v || arrive;
      skid_v <= 1'b0;
    end else if (arrive) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      if (skid_v) begin
        out_hit  <= skid_hit;
        out_dist <= skid_dist;
      end else begin
        out_hit  <= s_hit;
        out_dist <= new_dist;
      end
    end else if (arrive) begin
      skid_hit  <= s_hit;
      skid_dist <= new_dist;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{(40 - DistW){1'b0}}, out_dist};
  assign m_tuser  = out_hit;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  import rsi_pkg::*;

  // An index past the last segment register; writes to it must be ignored.
  localparam logic [7:0] REG_UNUSED = 8'd7;
  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 110;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct packed {
    logic signed [31:0] dy;
    logic signed [31:0] dx;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [32:0] distance;
  } crossing_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // origin_x, origin_y, dir_x, dir_y
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;   // distance, zero fill
  logic         m_tuser;   // hit

  // Segment registers as the predictor sees them.
  logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;

  crossing_t pending_crossings[$];
  int mismatches;
  int idle_cycles;
  int burst_left;
  bit gaps_on;
  int ready_pct;
  bit hold_req;
  int hold_left;

  ray_segment_intersection_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Signed quotient truncated toward zero, magnitude clamped at 2^40.
  function automatic logic signed [127:0] clamp_quot(logic signed [127:0] n,
                                                     logic signed [127:0] d);
    logic [127:0] nm, dm, q;
    nm = n[127] ? -n : n;
    dm = d[127] ? -d : d;
    q = nm / dm;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (n[127] ^ d[127]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic bit off_span(logic signed [127:0] r, logic signed [127:0] p,
                                  logic signed [127:0] q);
    return (r > p && r > q) || (r < p && r < q);
  endfunction

  function automatic int sign_of(logic signed [127:0] v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Crossing of the ray with the held segment, and its distance.
  function automatic crossing_t predict_crossing(ray_t r);
    logic signed [127:0] ox, oy, dx, dy, sx, sy, tx, ty, spx, spy;
    logic signed [127:0] det, cross0, nx, ny, rx, ry, ux, uy, sum;
    logic [127:0] cand;
    logic [33:0] root;
    crossing_t res;
    res.hit = 1'b0;
    res.distance = '0;
    ox = r.ox; oy = r.oy; dx = r.dx; dy = r.dy;
    sx = seg_sx; sy = seg_sy; tx = seg_ex; ty = seg_ey;
    if (dx == 0 && dy == 0) return res;
    spx = sx - tx;
    spy = sy - ty;
    det = spx * dy - spy * dx;
    if (det == 0) return res;
    cross0 = sx * ty - sy * tx;
    nx = cross0 * dx - spx * dx * oy + spx * dy * ox;
    ny = cross0 * dy - spy * dx * oy + spy * dy * ox;
    rx = clamp_quot(nx, det);
    ry = clamp_quot(ny, det);
    if (off_span(rx, sx, tx) || off_span(ry, sy, ty)) return res;
    ux = rx - ox;
    uy = ry - oy;
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      if (sign_of(ux) != sign_of(dx)) return res;
    end else if (sign_of(uy) != sign_of(dy)) begin
      return res;
    end
    sum = ux * ux + uy * uy;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = {94'd0, root} | (128'd1 << b);
      if ($unsigned(sum) >= cand * cand) root = cand[33:0];
    end
    res.hit = 1'b1;
    res.distance = root[32:0];
    return res;
  endfunction

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result hit=%0b distance=%0h", m_tuser, m_tdata[32:0]);
      end else begin
        want = pending_crossings.pop_front();
        if (want.hit !== m_tuser || want.distance !== m_tdata[32:0]
            || m_tdata[39:33] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b distance=%0h, got hit=%0b tdata=%0h",
                     want.hit, want.distance, m_tuser, m_tdata);
        end
      end
    end
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Offer one ray, honoring the sender's burst and gap pattern.
  task automatic send_ray(input ray_t r);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= r;
    do @(posedge clk); while (!s_tready);
    pending_crossings.push_back(predict_crossing(r));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_crossings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEG_START_X: seg_sx = val;
      REG_SEG_START_Y: seg_sy = val;
      REG_SEG_END_X:   seg_ex = val;
      REG_SEG_END_Y:   seg_ey = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (8) @(posedge clk);
  endtask

  task automatic set_segment(input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] bx, input logic [31:0] by);
    write_reg(REG_SEG_START_X, ax);
    write_reg(REG_SEG_START_Y, ay);
    write_reg(REG_SEG_END_X, bx);
    write_reg(REG_SEG_END_Y, by);
  endtask

  function automatic ray_t make_ray(logic [31:0] ox, logic [31:0] oy,
                                    logic [31:0] dx, logic [31:0] dy);
    ray_t r;
    r.ox = ox; r.oy = oy; r.dx = dx; r.dy = dy;
    return r;
  endfunction

  // Ray aimed at a random point of the segment from up to three direction steps back, or one step past it.
  function automatic ray_t aimed_ray();
    logic signed [63:0] px, py, dx, dy, k;
    int frac;
    int back;
    frac = $urandom_range(0, 256);
    back = $urandom_range(0, 4);
    px = seg_sx + ((64'(seg_ex) - 64'(seg_sx)) * frac) / 256;
    frac = $urandom_range(0, 256);
    py = seg_sy + ((64'(seg_ey) - 64'(seg_sy)) * frac) / 256;
    dx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    dy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    k = back - 1;
    return make_ray(32'(px - k * dx), 32'(py - k * dy), 32'(dx), 32'(dy));
  endfunction

  function automatic ray_t noise_ray();
    return make_ray($urandom, $urandom, $urandom, $urandom);
  endfunction

  // Vertical segment x=0, y in [-10,10]: each named miss case and some hits; then extreme and degenerate segments.
  task automatic test_directed();
    set_segment(32'sh0, -10 * ONE, 32'sh0, 10 * ONE);
    send_ray(make_ray(-5 * ONE, 0, 0, 0));          // zero direction
    send_ray(make_ray(-5 * ONE, 0, 0, ONE));        // parallel
    send_ray(make_ray(-5 * ONE, 0, ONE, 0));        // hit, distance 5
    send_ray(make_ray(5 * ONE, 0, ONE, 0));         // behind origin
    send_ray(make_ray(0, 0, ONE, 0));               // crossing at the origin
    send_ray(make_ray(-5 * ONE, 20 * ONE, ONE, 0)); // beyond the box
    send_ray(make_ray(-5 * ONE, 10 * ONE, ONE, 0)); // on the endpoint
    send_ray(make_ray(-ONE, -5 * ONE, ONE, 2 * ONE));  // y dominant
    send_ray(make_ray(-ONE, 5 * ONE, ONE, -ONE));   // equal magnitudes
    send_ray(make_ray(SMIN, 0, SMAX, 1));
    send_ray(make_ray(SMAX, SMIN, SMIN, SMAX));
    send_ray(make_ray(SMIN, SMIN, SMAX, SMAX));
    send_ray(make_ray(SMAX, SMAX, SMIN, SMIN));
    send_ray(make_ray(-ONE, 0, 1, SMIN));
    send_ray(make_ray(32'hffffffff, 0, 1, 0));
    // Extreme segment corners.
    set_segment(SMIN, SMIN, SMAX, SMAX);
    send_ray(make_ray(SMIN, SMAX, SMAX, SMIN));
    send_ray(make_ray(SMAX, SMIN, SMIN, SMAX));
    send_ray(make_ray(0, SMIN, 0, SMAX));
    send_ray(make_ray(SMIN, 0, 1, 0));
    // Degenerate segment, then an ignored register index.
    set_segment(ONE, ONE, ONE, ONE);
    send_ray(make_ray(0, 0, ONE, ONE));
    write_reg(REG_UNUSED, 32'h12345678);
    send_ray(make_ray(0, 0, ONE, 2 * ONE));
  endtask

  // Random segments; mostly aimed rays, some full-range noise.
  task automatic test_random(input int n_rays);
    logic [31:0] coord[4];
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 4; i++)
        coord[i] = (phase == 5) ? $urandom : 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      set_segment(coord[0], coord[1], coord[2], coord[3]);
      gaps_on = (phase % 2 == 0);
      ready_pct = (phase == 1) ? 100 : 40 + 10 * phase;
      for (int i = 0; i < n_rays / 6; i++)
        send_ray(($urandom_range(0, 99) < 70) ? aimed_ray() : noise_ray());
    end
  endtask

  // Long receiver hold-off while rays keep coming, then a full drain pause and a gapped burst.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    ready_pct = 90;
    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) send_ray(aimed_ray());
    stop_sending();
    wait_drained();
    gaps_on = 1'b1;
    for (int i = 0; i < 60; i++) send_ray(aimed_ray());
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    ready_pct = 70;
    hold_req = 1'b0;
    hold_left = 0;
    seg_sx = '0; seg_sy = '0; seg_ex = '0; seg_ey = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(900);
    test_backpressure();
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_crossings.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
